[hdl/priority_voice_allocator_core_assert.svh]
// Assertion macros for the priority voice allocator core.
`ifndef PRIORITY_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define PRIORITY_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("priority voice allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("priority voice allocator check failed");

`endif

[hdl/pva_pkg.sv]
// Package with the field widths and codes of the priority voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

    // Field widths on the stream ports.
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int HANDLE_W  = 8;
    localparam int IO_PRIO_W = 16;
    localparam int CFG_W     = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Register value after reset.
    localparam int VOICE_LIMIT_RESET = 255;

    // Request functions.
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PRIO   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ALWAYS = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE       = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SAMPLE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PRIO   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE = 3'd4;

endpackage

[hdl/pva_cell.sv]
// One voice slot cell: holds the slot's priority and salt and forwards the scan carry.
`timescale 1ns / 1ps

module pva_cell #(
    parameter int  IDX           = 1,
    parameter int  IDX_W         = 8,
    parameter int  LOOK_W        = 8,
    parameter int  SALT_BITS     = 8,
    parameter int  PRIORITY_BITS = 16,
    parameter type cmd_t         = logic,
    parameter type carry_t       = logic
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  cmd_t   cmd,
    input  carry_t carry_in,
    output carry_t carry_out
);

    logic signed [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [SALT_BITS-1:0]            salt_reg, salt_next;
    carry_t                          carry_reg, carry_next;
    logic                            take_min;

    // Slot state update: a table clear wins, otherwise an addressed write.
    always_comb begin
        prio_next = prio_reg;
        salt_next = salt_reg;
        if (cmd.clr) begin
            prio_next = '0;
            salt_next = cmd.clr_salt;
        end else if (cmd.wr_idx == IDX_W'(IDX)) begin
            if (cmd.wr_prio_en) begin
                prio_next = cmd.wr_prio;
            end
            if (cmd.wr_salt_en) begin
                salt_next = cmd.wr_salt;
            end
        end
    end

    // The first cell seeds the minimum; later active cells replace it only when strictly lower,
    // so ties stay with the lowest slot.
    always_comb begin
        carry_next = carry_in;
        if (IDX == 1) begin
            take_min = 1'b1;
        end else begin
            take_min = (IDX_W'(IDX) <= cmd.active_n) && (prio_reg < carry_in.min_prio);
        end
        if (take_min) begin
            carry_next.min_prio = prio_reg;
            carry_next.min_idx  = IDX_W'(IDX);
            carry_next.min_salt = salt_reg;
        end
        if (cmd.look_idx == LOOK_W'(IDX)) begin
            carry_next.hit_salt = salt_reg;
            carry_next.hit_prio = prio_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_reg <= '0;
            salt_reg <= SALT_BITS'(1);
        end else begin
            prio_reg <= prio_next;
            salt_reg <= salt_next;
        end
    end

    // The carry is pure payload and flushes through the row within one sweep.
    always_ff @(posedge aclk) begin
        carry_reg <= carry_next;
    end

    assign carry_out = carry_reg;

endmodule

[hdl/priority_voice_allocator_core.sv]
// Top level of the priority voice allocator: request handling, slot row and result register.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tuser func, s_tdata request fields
//  m_        out        m_tvalid/m_tready  m_tuser status, m_tdata handle and priority
//  cfg_      in         cfg_wen            cfg_wdata voice limit
//
// Each request is accepted, the scan carry passes along the row of slot cells (one cell per cycle),
// and then the result is committed.
// The commit waits while a previous result is still held in the output register.
// Reset is synchronous and active low; it clears all slots at once (priority 0, salt 1).
// A configuration write clears the row; it is expected only while no
// request is in flight.
`timescale 1ns / 1ps

module priority_voice_allocator_core #(
    parameter int VOICE_SLOTS   = 255,
    parameter int SALT_BITS     = 8,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: sample_found [0], request_priority [16:1], handle_index [24:17],
    //          handle_salt [32:25], zero padding [39:33].
    input  logic [pva_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func [1:0].
    input  logic [pva_pkg::FUNC_W-1:0]    s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: out_index [7:0], out_salt [15:8], out_priority [31:16].
    output logic [pva_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: status [2:0].
    output logic [pva_pkg::STATUS_W-1:0]  m_tuser,
    // Configuration register.
    input  logic                          cfg_wen,
    input  logic [pva_pkg::CFG_W-1:0]     cfg_wdata
);

    import pva_pkg::*;

    `include "priority_voice_allocator_core_assert.svh"

    localparam int IW     = $clog2(VOICE_SLOTS + 1);
    localparam int LOOK_W = (IW > HANDLE_W) ? IW : HANDLE_W;
    localparam int RESET_ACTIVE = (VOICE_LIMIT_RESET > VOICE_SLOTS) ? VOICE_SLOTS
                                                                    : VOICE_LIMIT_RESET;

    localparam logic [1:0] STATE_IDLE = 2'd0;
    localparam logic [1:0] STATE_SCAN = 2'd1;
    localparam logic [1:0] STATE_DONE = 2'd2;

    typedef struct packed {
        logic signed [PRIORITY_BITS-1:0] min_prio;
        logic [IW-1:0]                   min_idx;
        logic [SALT_BITS-1:0]            min_salt;
        logic [SALT_BITS-1:0]            hit_salt;
        logic signed [PRIORITY_BITS-1:0] hit_prio;
    } carry_t;

    typedef struct packed {
        logic                            clr;
        logic [SALT_BITS-1:0]            clr_salt;
        logic                            wr_prio_en;
        logic                            wr_salt_en;
        logic [IW-1:0]                   wr_idx;
        logic signed [PRIORITY_BITS-1:0] wr_prio;
        logic [SALT_BITS-1:0]            wr_salt;
        logic [IW-1:0]                   active_n;
        logic [LOOK_W-1:0]               look_idx;
    } cmd_t;

    // Control and request registers.
    logic [1:0]                      state_reg, state_next;
    logic [IW-1:0]                   cnt_reg, cnt_next;
    logic [FUNC_W-1:0]               func_reg, func_next;
    logic                            found_reg, found_next;
    logic signed [PRIORITY_BITS-1:0] req_reg, req_next;
    logic [LOOK_W-1:0]               hidx_reg, hidx_next;
    logic [SALT_BITS-1:0]            hsalt_reg, hsalt_next;
    logic [LOOK_W-1:0]               look_reg, look_next;
    logic [IW-1:0]                   active_reg, active_next;
    logic [IW:0]                     fresh_reg, fresh_next;
    logic [SALT_BITS-1:0]            gsalt_reg, gsalt_next;

    // Result registers.
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]             status_reg, status_next;
    logic [HANDLE_W-1:0]             oidx_reg, oidx_next;
    logic [HANDLE_W-1:0]             osalt_reg, osalt_next;
    logic [IO_PRIO_W-1:0]            oprio_reg, oprio_next;

    // Request field unpacking and width adaptation.
    logic                            in_found;
    logic [IO_PRIO_W-1:0]            in_req16;
    logic [HANDLE_W-1:0]             in_hidx;
    logic [HANDLE_W-1:0]             in_hsalt;
    logic [PRIORITY_BITS+IO_PRIO_W-1:0] req_wide;
    logic [LOOK_W+HANDLE_W-1:0]      hidx_wide;
    logic [SALT_BITS+HANDLE_W-1:0]   hsalt_wide;
    logic [LOOK_W+HANDLE_W-1:0]      cfg_wide;
    logic [LOOK_W-1:0]               cfg_clamped;
    logic [LOOK_W+IW:0]              fresh_wide;

    // Result computation.
    carry_t                          chain [0:VOICE_SLOTS];
    carry_t                          last;
    cmd_t                            cell_cmd;
    logic                            out_free;
    logic                            commit;
    logic                            fresh_avail;
    logic [STATUS_W-1:0]             res_status;
    logic [IW-1:0]                   res_idx;
    logic [SALT_BITS-1:0]            res_salt;
    logic signed [PRIORITY_BITS-1:0] res_prio;
    logic [SALT_BITS-1:0]            steal_salt;
    logic [IW+HANDLE_W-1:0]          res_idx_wide;
    logic [SALT_BITS+HANDLE_W-1:0]   res_salt_wide;
    logic [PRIORITY_BITS+IO_PRIO_W-1:0] res_prio_wide;

    assign in_found = s_tdata[0];
    assign in_req16 = s_tdata[16:1];
    assign in_hidx  = s_tdata[24:17];
    assign in_hsalt = s_tdata[32:25];

    // Sign-extend the priority, zero-extend the handle, then take the working widths.
    assign req_wide   = {{PRIORITY_BITS{in_req16[IO_PRIO_W-1]}}, in_req16};
    assign hidx_wide  = {{LOOK_W{1'b0}}, in_hidx};
    assign hsalt_wide = {{SALT_BITS{1'b0}}, in_hsalt};
    assign cfg_wide   = {{LOOK_W{1'b0}}, cfg_wdata};
    assign fresh_wide = {{LOOK_W{1'b0}}, fresh_reg};

    // Clamp the written slot count into one to VOICE_SLOTS.
    always_comb begin
        cfg_clamped = cfg_wide[LOOK_W-1:0];
        if (cfg_clamped == '0) begin
            cfg_clamped = LOOK_W'(1);
        end else if (cfg_clamped > LOOK_W'(VOICE_SLOTS)) begin
            cfg_clamped = LOOK_W'(VOICE_SLOTS);
        end
    end

    assign last        = chain[VOICE_SLOTS];
    assign out_free    = !m_tvalid_reg || m_tready;
    assign commit      = (state_reg == STATE_DONE) && out_free;
    assign fresh_avail = fresh_reg <= {1'b0, active_reg};
    assign steal_salt  = last.min_salt + SALT_BITS'(1);

    // Decide the outcome of the request from the scan carry.
    always_comb begin
        res_status = STATUS_OK;
        res_idx    = '0;
        res_salt   = '0;
        res_prio   = '0;
        fresh_next = fresh_reg;
        gsalt_next = gsalt_reg;

        cell_cmd            = '0;
        cell_cmd.clr_salt   = gsalt_reg;
        cell_cmd.wr_prio    = req_reg;
        cell_cmd.wr_salt    = steal_salt;
        cell_cmd.active_n   = active_reg;
        cell_cmd.look_idx   = look_reg;

        if (func_reg == FUNC_QUERY) begin
            if (hidx_reg == '0 || hidx_reg > LOOK_W'(VOICE_SLOTS) ||
                last.hit_salt != hsalt_reg) begin
                res_status = STATUS_BAD_HANDLE;
            end else begin
                res_prio = last.hit_prio;
            end
        end else if (!found_reg) begin
            res_status = STATUS_BAD_SAMPLE;
        end else if (req_reg <= 0) begin
            res_status = STATUS_BAD_PRIO;
        end else if (fresh_avail) begin
            res_idx  = fresh_reg[IW-1:0];
            res_salt = last.hit_salt;
            cell_cmd.wr_idx     = fresh_reg[IW-1:0];
            cell_cmd.wr_prio_en = commit;
            if (commit) begin
                fresh_next = fresh_reg + (IW + 1)'(1);
            end
        end else if (func_reg == FUNC_FREE) begin
            res_status = STATUS_NONE;
        end else if (func_reg == FUNC_ALWAYS || req_reg >= last.min_prio) begin
            res_idx  = last.min_idx;
            res_salt = steal_salt;
            cell_cmd.wr_idx     = last.min_idx;
            cell_cmd.wr_prio_en = commit;
            cell_cmd.wr_salt_en = commit;
            if (commit && steal_salt > gsalt_reg) begin
                gsalt_next = steal_salt + SALT_BITS'(1);
            end
        end else begin
            res_status = STATUS_NONE;
        end

        // A register write restarts the table; the user must write it only while idle, the block does not enforce this.
        if (cfg_wen) begin
            cell_cmd.clr = 1'b1;
            fresh_next   = (IW + 1)'(1);
        end
    end

    assign res_idx_wide  = {{HANDLE_W{1'b0}}, res_idx};
    assign res_salt_wide = {{HANDLE_W{1'b0}}, res_salt};
    assign res_prio_wide = {{IO_PRIO_W{res_prio[PRIORITY_BITS-1]}}, res_prio};

    // Sequencing: accept, sweep the row, then commit into the result register.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        func_next     = func_reg;
        found_next    = found_reg;
        req_next      = req_reg;
        hidx_next     = hidx_reg;
        hsalt_next    = hsalt_reg;
        look_next     = look_reg;
        active_next   = active_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        oidx_next     = oidx_reg;
        osalt_next    = osalt_reg;
        oprio_next    = oprio_reg;

        if (cfg_wen) begin
            active_next = cfg_clamped[IW-1:0];
        end

        case (state_reg)
            STATE_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    found_next = in_found;
                    req_next   = req_wide[PRIORITY_BITS-1:0];
                    hidx_next  = hidx_wide[LOOK_W-1:0];
                    hsalt_next = hsalt_wide[SALT_BITS-1:0];
                    if (s_tuser == FUNC_QUERY) begin
                        look_next = hidx_wide[LOOK_W-1:0];
                    end else begin
                        look_next = fresh_wide[LOOK_W-1:0];
                    end
                    cnt_next   = IW'(VOICE_SLOTS - 1);
                    state_next = STATE_SCAN;
                end
            end
            STATE_SCAN: begin
                if (cnt_reg == '0) begin
                    state_next = STATE_DONE;
                end else begin
                    cnt_next = cnt_reg - IW'(1);
                end
            end
            STATE_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    status_next   = res_status;
                    oidx_next     = res_idx_wide[HANDLE_W-1:0];
                    osalt_next    = res_salt_wide[HANDLE_W-1:0];
                    oprio_next    = res_prio_wide[IO_PRIO_W-1:0];
                    state_next    = STATE_IDLE;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_IDLE;
            cnt_reg      <= '0;
            active_reg   <= IW'(RESET_ACTIVE);
            fresh_reg    <= (IW + 1)'(1);
            gsalt_reg    <= SALT_BITS'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            active_reg   <= active_next;
            fresh_reg    <= fresh_next;
            gsalt_reg    <= gsalt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        found_reg  <= found_next;
        req_reg    <= req_next;
        hidx_reg   <= hidx_next;
        hsalt_reg  <= hsalt_next;
        look_reg   <= look_next;
        status_reg <= status_next;
        oidx_reg   <= oidx_next;
        osalt_reg  <= osalt_next;
        oprio_reg  <= oprio_next;
    end

    // Row of slot cells; the scan carry enters at the first cell.
    assign chain[0] = '0;

    for (genvar g = 1; g <= VOICE_SLOTS; g++) begin : g_cell
        pva_cell #(
            .IDX          (g),
            .IDX_W        (IW),
            .LOOK_W       (LOOK_W),
            .SALT_BITS    (SALT_BITS),
            .PRIORITY_BITS(PRIORITY_BITS),
            .cmd_t        (cmd_t),
            .carry_t      (carry_t)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cell_cmd),
            .carry_in (chain[g-1]),
            .carry_out(chain[g])
        );
    end

    assign s_tready = (state_reg == STATE_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {oprio_reg, osalt_reg, oidx_reg};

    // Checks on the sequencing and the slot bookkeeping.
    `PVA_ASSERT_NEXT(a_accept_starts_scan, s_tvalid && s_tready, state_reg == STATE_SCAN)
    `PVA_ASSERT_IMPL(a_result_from_done, $rose(m_tvalid_reg), $past(state_reg) == STATE_DONE)
    `PVA_ASSERT_IMPL(a_steal_only_when_full, cell_cmd.wr_salt_en, !fresh_avail)
    `PVA_ASSERT_IMPL(a_fresh_nonzero, 1'b1, fresh_reg != '0)

endmodule
